@@ sv/lzss_pkg.sv @@
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS ring decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

    // Default history ring depth in bytes. The depth must be a power of two.
    localparam int RING_SIZE_DEF = 4096;

    // Ring write position after reset (0xFEE).
    localparam logic [11:0] START_POS_RST = 12'hFEE;

    // Configuration port address width: two 32-bit registers at byte 0 and 4.
    localparam int CFG_AW = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_OUTPUT_LENGTH  = 1'b0;
    localparam logic REG_START_POSITION = 1'b1;

    // Configuration register contents handed from the register block.
    typedef struct packed {
        logic [30:0] output_length;
        logic [11:0] start_position;
    } t_cfg;

endpackage

@@ sv/lzss_apb.sv @@
// ----------------------------------------------------------------------------
// lzss_apb
// APB-style configuration registers: output length and start position.
// ----------------------------------------------------------------------------
module lzss_apb
    import lzss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_length  <= '0;
            r_cfg.start_position <= START_POS_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_OUTPUT_LENGTH:  r_cfg.output_length  <= pwdata[30:0];
                REG_START_POSITION: r_cfg.start_position <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OUTPUT_LENGTH:  prdata = {1'b0, r_cfg.output_length};
            REG_START_POSITION: prdata = {20'd0, r_cfg.start_position};
            default:            prdata = '0;
        endcase
    end

endmodule

@@ sv/lzss_ring.sv @@
// ----------------------------------------------------------------------------
// lzss_ring
// History ring memory with a fill count that stands in for clearing.
// ----------------------------------------------------------------------------
module lzss_ring
    import lzss_pkg::*;
#(
    parameter int RING_SIZE = RING_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic [$clog2(RING_SIZE)-1:0] i_base,
    input  logic                         i_wr_en,
    input  logic [$clog2(RING_SIZE)-1:0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(RING_SIZE)-1:0] i_rd_addr,
    output logic [7:0]                   o_rd_data
);

    localparam int AW = $clog2(RING_SIZE);

    logic [7:0]  mem [RING_SIZE];
    logic [7:0]  r_q;
    logic        r_hit;
    logic [AW:0] r_fill;
    logic [AW-1:0] r_base;
    logic [AW-1:0] w_offset;
    logic        w_hit;

    // Writes run sequentially from the base, so an entry holds stream data
    // exactly when its distance from the base is below the fill count.
    assign w_offset  = i_rd_addr - r_base;
    assign w_hit     = {1'b0, w_offset} < r_fill;
    assign o_rd_data = r_hit ? r_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_base <= AW'(START_POS_RST);
        end else if (i_clear) begin
            r_fill <= '0;
            r_base <= i_base;
        end else if (i_wr_en && (r_fill != (AW+1)'(RING_SIZE))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q   <= mem[i_rd_addr];
            r_hit <= w_hit;
        end
    end

endmodule

@@ sv/lzss_ring_decompressor_core.sv @@
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_core
// LZSS (4 KiB ring) byte-stream decompressor.
// ----------------------------------------------------------------------------
// Compressed bytes enter one transfer at a time and decoded bytes leave one
// transfer at a time. A flag byte or a back-reference low byte is absorbed in
// S_IDLE and produces nothing. A literal also passes through S_IDLE and then
// S_EMIT, where it is loaded into the output register. A back-reference of
// length L (3 to 18) occupies the block for L passes through S_READ and
// S_EMIT: each copied byte is read from the ring memory in S_READ, then driven
// to the output and written back at the write position in S_EMIT; the next
// copy read therefore always sees the byte just written, which is what an
// overlapping copy needs. The input is stalled while a symbol is being
// emitted, and any output stall lengthens that time. The ring needs no
// clearing pass: a fill count, reset at each stream start, marks which
// entries hold stream data, and all other entries read as zero. Register
// writes are picked up at the next transfer that carries stream_start.
// RING_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor_core
    import lzss_pkg::*;
#(
    parameter int RING_SIZE = RING_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Compressed input channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_stream_start,
    // Decoded output channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_finished
);

    localparam int AW = $clog2(RING_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    t_cfg w_cfg;

    // Control registers.
    t_state        r_state,  n_state;
    logic [AW-1:0] r_wp,     n_wp;
    logic [8:0]    r_fs,     n_fs;
    logic          r_high,   n_high;
    logic [30:0]   r_owed,   n_owed;
    logic [4:0]    r_cnt,    n_cnt;
    logic          r_ovalid, n_ovalid;
    // Payload registers.
    logic [7:0]    r_low,    n_low;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_copy,   n_copy;
    logic [7:0]    r_pend,   n_pend;
    logic [7:0]    r_obyte,  n_obyte;
    logic          r_olast,  n_olast;
    logic          r_ofin,   n_ofin;

    // Decode state as seen by the incoming byte, after a stream start.
    logic [8:0]    e_fs;
    logic          e_high;
    logic [7:0]    e_low;
    logic [30:0]   e_owed;

    logic          w_clear;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [7:0]    w_rd_data;
    logic [7:0]    w_byte;
    logic          w_out_free;

    lzss_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lzss_ring #(
        .RING_SIZE (RING_SIZE)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_base    (AW'(w_cfg.start_position)),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (w_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_run_last  = r_olast;
    assign o_finished  = r_ofin;

    // A stream start resets the decode state before the byte is looked at.
    assign e_fs   = i_stream_start ? 9'd0 : r_fs;
    assign e_high = i_stream_start ? 1'b0 : r_high;
    assign e_low  = i_stream_start ? 8'd0 : r_low;
    assign e_owed = i_stream_start ? w_cfg.output_length : r_owed;

    assign w_clear    = (r_state == S_IDLE) && i_in_valid && i_stream_start;
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_byte     = r_copy ? w_rd_data : r_pend;

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_fs      = r_fs;
        n_high    = r_high;
        n_owed    = r_owed;
        n_cnt     = r_cnt;
        n_low     = r_low;
        n_rd_addr = r_rd_addr;
        n_copy    = r_copy;
        n_pend    = r_pend;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        n_ofin    = r_ofin;
        n_ovalid  = r_ovalid && i_out_stall;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_fs   = e_fs;
                    n_high = e_high;
                    n_low  = e_low;
                    n_owed = e_owed;
                    if (i_stream_start) begin
                        n_wp = AW'(w_cfg.start_position);
                    end
                    // With nothing owed the byte is dropped.
                    if (e_owed != 31'd0) begin
                        if (e_high) begin
                            // High byte of a back-reference: start the copy.
                            n_rd_addr = AW'({i_in_byte[7:4], e_low});
                            n_cnt     = 5'(i_in_byte[3:0]) + 5'd2;
                            n_copy    = 1'b1;
                            n_high    = 1'b0;
                            n_fs      = {1'b0, e_fs[8:1]};
                            n_state   = S_READ;
                        end else if (e_fs < 9'd2) begin
                            // Flag byte: a marker bit above eight symbol types.
                            n_fs = {1'b1, i_in_byte};
                        end else if (e_fs[0]) begin
                            n_pend  = i_in_byte;
                            n_cnt   = 5'd0;
                            n_copy  = 1'b0;
                            n_fs    = {1'b0, e_fs[8:1]};
                            n_state = S_EMIT;
                        end else begin
                            n_low  = i_in_byte;
                            n_high = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    // Emit, write into the ring and count down what is owed.
                    w_wr_en  = 1'b1;
                    n_ovalid = 1'b1;
                    n_obyte  = w_byte;
                    n_olast  = (r_cnt == 5'd0);
                    n_ofin   = (r_owed <= 31'd1);
                    n_owed   = (r_owed != 31'd0) ? r_owed - 31'd1 : 31'd0;
                    n_wp     = r_wp + 1'b1;
                    if (r_cnt == 5'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt     = r_cnt - 5'd1;
                        n_rd_addr = r_rd_addr + 1'b1;
                        n_state   = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= AW'(START_POS_RST);
            r_fs     <= '0;
            r_high   <= 1'b0;
            r_owed   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_fs     <= n_fs;
            r_high   <= n_high;
            r_owed   <= n_owed;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_low     <= n_low;
        r_rd_addr <= n_rd_addr;
        r_copy    <= n_copy;
        r_pend    <= n_pend;
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
        r_ofin    <= n_ofin;
    end

endmodule

@@ sv/lzss_checker.sv @@
// ----------------------------------------------------------------------------
// lzss_checker
// Port-level assertions for the LZSS ring decompressor, bound to the core.
// ----------------------------------------------------------------------------
module lzss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_finished
);

    // A stalled output transfer keeps its valid and payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_run_last) && $stable(o_finished))
        else $error("output payload changed while stalled");

    // While a symbol still has bytes to come, no new input is taken.
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> o_in_stall)
        else $error("input ready in the middle of a run");

    // A new decoded byte only follows a cycle in which the block was busy.
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output appeared without a busy cycle");

endmodule

bind lzss_ring_decompressor_core lzss_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last),
    .o_finished  (o_finished)
);
